// File: hw/rtl/tbd_pkg.sv
// ----------------------------------------------------------------------------
// Texture block decoder package
// Mode codes, palette arithmetic and the constant-divide helpers that the
// BC1/BC3/BC4 decoder shares.
// ----------------------------------------------------------------------------
package tbd_pkg;

  localparam logic [1:0] MODE_BC1 = 2'd0;
  localparam logic [1:0] MODE_BC3 = 2'd1;
  localparam logic [1:0] MODE_BC4 = 2'd2;
  localparam logic [1:0] MODE_RSV = 2'd3;

  localparam int TEXELS = 16;
  localparam int POS_W = $clog2(TEXELS);
  localparam int CSEL_W = 2;
  localparam int VSEL_W = 3;
  localparam int VPAL_N = 8;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    byte_t r;
    byte_t g;
    byte_t b;
  } rgb_t;

  // Expand one RGB565 word to 8 bits per channel.
  function automatic rgb_t expand565(input logic [15:0] c);
    logic [13:0] r_s;
    logic [13:0] g_s;
    logic [13:0] b_s;
    rgb_t        res;
    r_s = 14'(c[15:11]) * 14'd527 + 14'd23;
    g_s = 14'(c[10:5]) * 14'd259 + 14'd33;
    b_s = 14'(c[4:0]) * 14'd527 + 14'd23;
    res.r = r_s[13:6];
    res.g = g_s[13:6];
    res.b = b_s[13:6];
    return res;
  endfunction

  // floor((2*near + far) / 3), exact by reciprocal for sums below 2048.
  function automatic byte_t third_chan(input byte_t near, input byte_t far);
    logic [9:0]  sum;
    logic [19:0] prod;
    sum  = {1'b0, near, 1'b0} + {2'b00, far};
    prod = 20'(sum) * 20'd683;
    return prod[18:11];
  endfunction

  function automatic rgb_t third_point(input rgb_t near, input rgb_t far);
    rgb_t res;
    res.r = third_chan(near.r, far.r);
    res.g = third_chan(near.g, far.g);
    res.b = third_chan(near.b, far.b);
    return res;
  endfunction

  // floor((w0*v0 + w1*v1 + 1) / 7) with w0 + w1 = 7, reciprocal exact below 5461.
  function automatic byte_t seventh_point(input byte_t v0, input byte_t v1,
                                          input logic [2:0] w1);
    logic [2:0]  w0;
    logic [10:0] sum;
    logic [22:0] prod;
    w0   = 3'd7 - w1;
    sum  = 11'(v0) * 11'(w0) + 11'(v1) * 11'(w1) + 11'd1;
    prod = 23'(sum) * 23'd2341;
    return prod[21:14];
  endfunction

endpackage

// File: hw/rtl/texture_block_decoder.sv
// Flow: a block held in the input register moves to the block register, which
// holds its palette; the single texel output register emits its sixteen texels
// from the held palette, one per cycle while the output is not stalled. The next
// block waits in the input register and enters as the last texel leaves.
// Reset: synchronous, active high; empties the input and block stages and
// the output register and clears the texel counter.
// ----------------------------------------------------------------------------
// Texture block decoder
// Decodes BC1, BC3 and BC4 4x4 blocks (reserved mode as BC1) into sixteen RGBA
// texels in raster order, through input, palette and output registers.
// ----------------------------------------------------------------------------
module texture_block_decoder
  import tbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [15:0] color_end_a,
  input  logic [15:0] color_end_b,
  input  logic [31:0] color_selectors,
  input  logic [7:0]  value_end_a,
  input  logic [7:0]  value_end_b,
  input  logic [47:0] value_selectors,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic [3:0]  texel_position,
  output logic        last
);

  // Input register.
  logic        in_full;
  logic [1:0]  in_mode;
  logic [15:0] in_cea;
  logic [15:0] in_ceb;
  logic [31:0] in_csel;
  logic [7:0]  in_vea;
  logic [7:0]  in_veb;
  logic [47:0] in_vsel;

  // Block register: expanded endpoints, value palette and selectors.
  logic               blk_full;
  logic [1:0]         blk_mode;
  rgb_t               blk_ca;
  rgb_t               blk_cb;
  byte_t              blk_vpal [VPAL_N];
  logic [31:0]        blk_csel;
  logic [47:0]        blk_vsel;
  logic [POS_W-1:0]   cnt;

  byte_t              vpal_next [VPAL_N];
  logic [1:0]         mode_next;

  logic step;
  logic blk_done;
  logic blk_load;
  logic in_load;

  assign step     = blk_full && (!out_valid || !out_stall);
  assign blk_done = step && (cnt == POS_W'(TEXELS - 1));
  assign blk_load = in_full && (!blk_full || blk_done);
  assign in_load  = in_valid && !in_stall;
  assign in_stall = in_full && !blk_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_load) begin
      in_full <= 1'b1;
    end else if (blk_load) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_mode <= mode;
      in_cea  <= color_end_a;
      in_ceb  <= color_end_b;
      in_csel <= color_selectors;
      in_vea  <= value_end_a;
      in_veb  <= value_end_b;
      in_vsel <= value_selectors;
    end
  end

  always_comb begin
    mode_next = (in_mode == MODE_RSV) ? MODE_BC1 : in_mode;
    vpal_next[0] = in_vea;
    vpal_next[1] = in_veb;
    for (int k = 1; k < VPAL_N - 1; k++) begin
      vpal_next[k + 1] = seventh_point(in_vea, in_veb, 3'(k));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_full <= 1'b0;
      cnt      <= '0;
    end else begin
      if (blk_load) begin
        blk_full <= 1'b1;
      end else if (blk_done) begin
        blk_full <= 1'b0;
      end
      if (step) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (blk_load) begin
      blk_mode <= mode_next;
      blk_ca   <= expand565(in_cea);
      blk_cb   <= expand565(in_ceb);
      blk_csel <= in_csel;
      blk_vsel <= in_vsel;
      for (int k = 0; k < VPAL_N; k++) begin
        blk_vpal[k] <= vpal_next[k];
      end
    end
  end

  // Texel selection from the held block.
  logic [CSEL_W-1:0] cidx;
  logic [VSEL_W-1:0] vidx;
  rgb_t              col;
  byte_t             val;
  byte_t             red_next;
  byte_t             green_next;
  byte_t             blue_next;
  byte_t             alpha_next;

  assign cidx = blk_csel[cnt * CSEL_W +: CSEL_W];
  assign vidx = blk_vsel[cnt * VSEL_W +: VSEL_W];
  assign val  = blk_vpal[vidx];

  always_comb begin
    case (cidx)
      2'd0:    col = blk_ca;
      2'd1:    col = blk_cb;
      2'd2:    col = third_point(blk_ca, blk_cb);
      default: col = third_point(blk_cb, blk_ca);
    endcase
  end

  always_comb begin
    unique case (blk_mode)
      MODE_BC4: begin
        red_next   = val;
        green_next = '0;
        blue_next  = '0;
        alpha_next = ALPHA_OPAQUE;
      end
      MODE_BC3: begin
        red_next   = col.r;
        green_next = col.g;
        blue_next  = col.b;
        alpha_next = val;
      end
      default: begin
        red_next   = col.r;
        green_next = col.g;
        blue_next  = col.b;
        alpha_next = ALPHA_OPAQUE;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      red            <= red_next;
      green          <= green_next;
      blue           <= blue_next;
      alpha          <= alpha_next;
      texel_position <= cnt;
      last           <= (cnt == POS_W'(TEXELS - 1));
    end
  end

  // The block stage empties only after its sixteenth texel.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(blk_full) && !blk_full |-> $past(cnt) == POS_W'(TEXELS - 1))
    else $error("block stage emptied before its last texel");

  // A held input moves on at once when the block stage is free.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(in_full && !blk_full) |-> blk_full)
    else $error("held input was not moved into a free block stage");

  // The input side stalls only while a transaction is held.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_full)
    else $error("input stalled with an empty input register");

  // A new block starts at texel zero.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(blk_full) && blk_full |-> cnt == '0)
    else $error("block started at a nonzero texel");

endmodule

// File: bench/tb_texture_block_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texture block decoder testbench
// Drives BC1, BC3, BC4 and reserved-mode blocks through the input channel
// with random gaps, and holds off the texel channel with random stalls. A
// predictor in this file expands each accepted block into its sixteen texels.
// Each texel the decoder delivers is checked field by field against them.
// ----------------------------------------------------------------------------
module tb_texture_block_decoder;
  import tbd_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int MAX_WAIT = 12;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] ca;
    logic [15:0] cb;
    logic [31:0] csel;
    logic [7:0]  va;
    logic [7:0]  vb;
    logic [47:0] vsel;
  } block_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [3:0] pos;
    logic       last;
  } texel_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  mode;
  logic [15:0] color_end_a;
  logic [15:0] color_end_b;
  logic [31:0] color_selectors;
  logic [7:0]  value_end_a;
  logic [7:0]  value_end_b;
  logic [47:0] value_selectors;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [3:0]  texel_position;
  logic        last;

  logic [23:0] color_points [4];
  logic [7:0]  value_points [8];
  logic [31:0] held_csel;
  logic [47:0] held_vsel;
  logic [1:0]  held_mode;
  logic [3:0]  texel_count;

  texel_t expected_texels [$];
  int     mismatch_count;
  int     texels_checked;
  int     texels_seen;
  int     blocks_by_mode [4];
  int     stall_left;
  int     idle_cycles;
  bit     sender_gaps_on;
  bit     receiver_stalls_on;

  texture_block_decoder i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .mode            (mode),
    .color_end_a     (color_end_a),
    .color_end_b     (color_end_b),
    .color_selectors (color_selectors),
    .value_end_a     (value_end_a),
    .value_end_b     (value_end_b),
    .value_selectors (value_selectors),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .red             (red),
    .green           (green),
    .blue            (blue),
    .alpha           (alpha),
    .texel_position  (texel_position),
    .last            (last)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [23:0] widen_565(input logic [15:0] c);
    int r;
    int g;
    int b;
    r = (int'(c[15:11]) * 527 + 23) >> 6;
    g = (int'(c[10:5]) * 259 + 33) >> 6;
    b = (int'(c[4:0]) * 527 + 23) >> 6;
    return {8'(r), 8'(g), 8'(b)};
  endfunction

  function automatic logic [23:0] blend_third(input logic [23:0] near_c,
                                              input logic [23:0] far_c);
    logic [23:0] res;
    int          v;
    for (int ch = 0; ch < 3; ch++) begin
      v = (2 * int'(near_c[8*ch +: 8]) + int'(far_c[8*ch +: 8])) / 3;
      res[8*ch +: 8] = 8'(v);
    end
    return res;
  endfunction

  function automatic void expand_block_texels(input block_t blk);
    texel_t t;
    logic [23:0] col;
    logic [7:0]  val;
    held_mode = (blk.mode == MODE_RSV) ? MODE_BC1 : blk.mode;
    color_points[0] = widen_565(blk.ca);
    color_points[1] = widen_565(blk.cb);
    color_points[2] = blend_third(color_points[0], color_points[1]);
    color_points[3] = blend_third(color_points[1], color_points[0]);
    held_csel = blk.csel;
    value_points[0] = blk.va;
    value_points[1] = blk.vb;
    for (int k = 1; k <= 6; k++) begin
      value_points[k + 1] = 8'(((7 - k) * int'(blk.va) + k * int'(blk.vb) + 1) / 7);
    end
    held_vsel = blk.vsel;
    for (int i = 0; i < TEXELS; i++) begin
      col = color_points[held_csel[2*i +: 2]];
      val = value_points[held_vsel[3*i +: 3]];
      if (held_mode == MODE_BC4) begin
        t.red = val;
        t.green = 8'd0;
        t.blue = 8'd0;
        t.alpha = ALPHA_OPAQUE;
      end else begin
        t.red = col[23:16];
        t.green = col[15:8];
        t.blue = col[7:0];
        t.alpha = (held_mode == MODE_BC3) ? val : ALPHA_OPAQUE;
      end
      t.pos = texel_count;
      t.last = (texel_count == 4'd15);
      texel_count = texel_count + 4'd1;
      expected_texels.push_back(t);
    end
  endfunction

  function automatic block_t make_block(input logic [1:0] m, input logic [15:0] ca,
                                        input logic [15:0] cb, input logic [31:0] csel,
                                        input logic [7:0] va, input logic [7:0] vb,
                                        input logic [47:0] vsel);
    block_t b;
    b.mode = m;
    b.ca = ca;
    b.cb = cb;
    b.csel = csel;
    b.va = va;
    b.vb = vb;
    b.vsel = vsel;
    return b;
  endfunction

  function automatic block_t random_block();
    block_t b;
    b.mode = ($urandom_range(0, 9) == 0) ? MODE_RSV : 2'($urandom_range(0, 2));
    b.ca = 16'($urandom);
    b.cb = 16'($urandom);
    b.csel = $urandom;
    b.va = 8'($urandom);
    b.vb = 8'($urandom);
    b.vsel = 48'({$urandom, $urandom});
    if ($urandom_range(0, 7) == 0) begin
      b.ca = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      b.va = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    if ($urandom_range(0, 7) == 0) begin
      b.cb = b.ca;
      b.vb = b.va;
    end
    return b;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 40) begin
      $display("Mismatch on texel %0d: %s is %0d, expected %0d",
               texels_checked, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic send_block(input block_t blk);
    int gap;
    gap = sender_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    mode <= blk.mode;
    color_end_a <= blk.ca;
    color_end_b <= blk.cb;
    color_selectors <= blk.csel;
    value_end_a <= blk.va;
    value_end_b <= blk.vb;
    value_selectors <= blk.vsel;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    blocks_by_mode[blk.mode]++;
    expand_block_texels(blk);
  endtask

  always @(negedge clk) begin
    if (texels_checked != texels_seen) begin
      texels_seen = texels_checked;
      stall_left = receiver_stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
    end
    if (rst || stall_left == 0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b1;
      stall_left--;
    end
  end

  always @(posedge clk) begin
    texel_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      texels_checked++;
      if (expected_texels.size() == 0) begin
        report_mismatch("unexpected texel at position", texel_position, -1);
      end else begin
        want = expected_texels.pop_front();
        if (red !== want.red) report_mismatch("red", red, want.red);
        if (green !== want.green) report_mismatch("green", green, want.green);
        if (blue !== want.blue) report_mismatch("blue", blue, want.blue);
        if (alpha !== want.alpha) report_mismatch("alpha", alpha, want.alpha);
        if (texel_position !== want.pos) begin
          report_mismatch("texel_position", texel_position, want.pos);
        end
        if (last !== want.last) report_mismatch("last", last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d texels still expected",
                 idle_cycles, expected_texels.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic test_bc1_endpoints();
    send_block(make_block(MODE_BC1, 16'h0000, 16'hFFFF, 32'hE4E4E4E4, 8'h00, 8'h00, '0));
    send_block(make_block(MODE_BC1, 16'hFFFF, 16'h0000, 32'h1B1B1B1B, 8'hFF, 8'hFF, '1));
    send_block(make_block(MODE_BC1, 16'hF800, 16'h07E0, 32'h00000000, 8'h12, 8'h34, '0));
    send_block(make_block(MODE_BC1, 16'h001F, 16'hF800, 32'h55555555, 8'h00, 8'hFF, '1));
    send_block(make_block(MODE_BC1, 16'h07E0, 16'h001F, 32'hAAAAAAAA, 8'hFF, 8'h00, '0));
    send_block(make_block(MODE_BC1, 16'h8410, 16'h8410, 32'hFFFFFFFF, 8'h80, 8'h7F, '1));
  endtask

  task automatic test_bc3_alpha();
    logic [47:0] ramp;
    for (int i = 0; i < TEXELS; i++) ramp[3*i +: 3] = 3'(i);
    send_block(make_block(MODE_BC3, 16'hFFFF, 16'h0000, 32'hE4E4E4E4, 8'h00, 8'hFF, ramp));
    send_block(make_block(MODE_BC3, 16'h0000, 16'hFFFF, 32'h1B1B1B1B, 8'hFF, 8'h00, ramp));
    send_block(make_block(MODE_BC3, 16'h1234, 16'hABCD, 32'hFFFFFFFF, 8'hFF, 8'hFF, '1));
    send_block(make_block(MODE_BC3, 16'hF81F, 16'h07E0, 32'h00000000, 8'h00, 8'h00, '0));
    send_block(make_block(MODE_BC3, 16'h7BEF, 16'h8410, 32'h9C9C9C9C, 8'h01, 8'hFE, ~ramp));
  endtask

  task automatic test_bc4_values();
    logic [47:0] ramp;
    for (int i = 0; i < TEXELS; i++) ramp[3*i +: 3] = 3'(7 - i);
    send_block(make_block(MODE_BC4, 16'h0000, 16'h0000, 32'h0, 8'h00, 8'hFF, ramp));
    send_block(make_block(MODE_BC4, 16'hFFFF, 16'hFFFF, '1, 8'hFF, 8'h00, ramp));
    send_block(make_block(MODE_BC4, 16'h0000, 16'hFFFF, 32'h0, 8'hFF, 8'hFF, '0));
    send_block(make_block(MODE_BC4, 16'hFFFF, 16'h0000, '1, 8'h00, 8'h00, '1));
    send_block(make_block(MODE_BC4, 16'h5A5A, 16'hA5A5, 32'h0, 8'h10, 8'h11, ~ramp));
  endtask

  task automatic test_reserved_mode();
    send_block(make_block(MODE_RSV, 16'hF800, 16'h001F, 32'hE4E4E4E4, 8'h00, 8'hFF, '1));
    send_block(make_block(MODE_RSV, 16'h0000, 16'hFFFF, 32'h4E4E4E4E, 8'hFF, 8'h00, '0));
  endtask

  task automatic test_ignored_fields();
    block_t b;
    b = random_block();
    b.mode = MODE_BC1;
    send_block(b);
    b = random_block();
    b.mode = MODE_BC4;
    send_block(b);
    b = random_block();
    b.mode = MODE_BC1;
    send_block(b);
  endtask

  task automatic test_random_blocks(input int count);
    int phase;
    for (int n = 0; n < count; n++) begin
      if (n % 45 == 0) begin
        phase = (n / 45) % 4;
        sender_gaps_on = (phase == 0 || phase == 2);
        receiver_stalls_on = (phase == 0 || phase == 3);
      end
      send_block(random_block());
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_BC1;
    color_end_a = '0;
    color_end_b = '0;
    color_selectors = '0;
    value_end_a = '0;
    value_end_b = '0;
    value_selectors = '0;
    out_stall = 1'b0;
    idle_cycles = 0;
    mismatch_count = 0;
    texels_checked = 0;
    blocks_by_mode = '{default: 0};
    texel_count = '0;
    held_csel = '0;
    held_vsel = '0;
    held_mode = MODE_BC1;
    color_points = '{default: '0};
    value_points = '{default: '0};
    sender_gaps_on = 1'b1;
    receiver_stalls_on = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_bc1_endpoints();
    test_bc3_alpha();
    test_bc4_values();
    test_reserved_mode();
    test_ignored_fields();
    test_random_blocks(450);

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_texels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Decoded %0d BC1, %0d BC3, %0d BC4 and %0d reserved-mode blocks,",
             blocks_by_mode[MODE_BC1], blocks_by_mode[MODE_BC3],
             blocks_by_mode[MODE_BC4], blocks_by_mode[MODE_RSV]);
    $display("checking %0d texels with %0d mismatches.", texels_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
